@@ hdl/line_keyword_risk_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// line_keyword_risk_scanner_assert: shared assertion macros
// clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_KEYWORD_RISK_SCANNER_ASSERT_SVH
`define LINE_KEYWORD_RISK_SCANNER_ASSERT_SVH

// same-cycle implication
`define KWRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kwrs assertion failed");

// next-cycle implication
`define KWRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kwrs assertion failed");

`endif

@@ hdl/kwrs_pkg.sv @@
// ----------------------------------------------------------------------------
// kwrs_pkg
// keyword tables, widths and shared types of the line keyword risk scanner
// ----------------------------------------------------------------------------
package kwrs_pkg;

	localparam int CH_W      = 8;
	localparam int IDX_W     = 16;
	localparam int MAX_LINES = 65536;
	localparam int LINE_W    = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;

	// longest keyword, one cell per keyword position
	localparam int CMP_LEN = 12;
	localparam int POS_W   = $clog2(CMP_LEN + 1);
	localparam int NUM_KW  = 17;

	typedef logic [NUM_KW-1:0]  kw_vec_t;
	typedef logic [CH_W-1:0]    kw_char_t;
	typedef kw_char_t [CMP_LEN-1:0] kw_row_t;
	typedef kw_row_t [NUM_KW-1:0]   kw_tbl_t;

	// control that every cell of the chain sees
	typedef struct packed {
		logic adv;   // an item is taken this cycle
		logic clr;   // that item closes its line
	} kwrs_ctl_t;

	// command words first, then overflow words, then memory words
	localparam logic [8*CMP_LEN-1:0] KW_STR [NUM_KW] = '{
		"system", "popen", "exec", "eval", "call", {"proc_", "open"}, "ShellExecute",
		"gets", "scanf", "strcpy", "strcat", "sprintf", "snprintf", "syslog",
		"memcpy", "memmove", "memset"
	};
	localparam int KW_LEN [NUM_KW] = '{
		6, 5, 4, 4, 4, 9, 12,
		4, 5, 6, 6, 7, 8, 6,
		6, 7, 6
	};

	localparam kw_vec_t CMD_MASK = kw_vec_t'(17'h0007F);
	localparam kw_vec_t OVF_MASK = kw_vec_t'(17'h03F80);
	localparam kw_vec_t MEM_MASK = kw_vec_t'(17'h1C000);

	// string literals sit right-justified, so the first letter is the highest byte
	function automatic kw_tbl_t build_kw_tbl();
		kw_tbl_t t;
		t = '0;
		for (int k = 0; k < NUM_KW; k++) begin
			for (int j = 0; j < CMP_LEN; j++) begin
				if (j < KW_LEN[k]) begin
					t[k][j] = KW_STR[k][8*(KW_LEN[k]-1-j) +: 8];
				end
			end
		end
		return t;
	endfunction

	localparam kw_tbl_t KW_AT = build_kw_tbl();

endpackage

@@ hdl/kwrs_cell.sv @@
// ----------------------------------------------------------------------------
// kwrs_cell
// one keyword position: extends every partial keyword match by the new byte
// ----------------------------------------------------------------------------
module kwrs_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kwrs_pkg::kwrs_ctl_t    ctl,
	input  logic [kwrs_pkg::POS_W-1:0] pos,
	input  logic [kwrs_pkg::CH_W-1:0]  ch,
	input  kwrs_pkg::kw_vec_t      prv,
	output kwrs_pkg::kw_vec_t      nxt,
	output kwrs_pkg::kw_vec_t      hit
);
	import kwrs_pkg::*;

	kw_vec_t ext;
	kw_vec_t nxt_q;

	// ext[k]: keyword k matched up to and including this position
	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			ext[k] = prv[k] && (pos < POS_W'(KW_LEN[k]))
				&& (ch == KW_AT[k][pos[POS_W-1:0]]);
			hit[k] = ext[k] && (pos == POS_W'(KW_LEN[k] - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_q <= '0;
		end else if (ctl.adv) begin
			nxt_q <= ctl.clr ? '0 : ext;
		end
	end

	assign nxt = nxt_q;

endmodule

@@ hdl/line_keyword_risk_scanner.sv @@
// a line's result is registered and shows on the output in the cycle after its last byte is taken
// throughput: one byte per cycle while in_stall is low, set by the single compare stage in each chain cell
// and by the one output register, which may hold a result while the next byte enters
// input stalls only while a result is held and the output side stalls
// reset (arst_n low) clears the match chain, the flags, the line counter and out_valid
// ----------------------------------------------------------------------------
// line_keyword_risk_scanner
// flags command, overflow and memory keywords per text line, one byte per item
// ----------------------------------------------------------------------------
module line_keyword_risk_scanner (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kwrs_pkg::CH_W-1:0]   ch,
	input  logic                        line_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kwrs_pkg::IDX_W-1:0]  line_index,
	output logic                        cmd_risk,
	output logic                        overflow_risk,
	output logic                        memory_risk
);
	import kwrs_pkg::*;

	// handshake
	logic accept;
	kwrs_ctl_t ctl;

	// chain of cells: chain[i] is the partial match vector entering cell i
	kw_vec_t chain [CMP_LEN];
	kw_vec_t hits  [CMP_LEN];
	kw_vec_t hit_all;

	// per-line state
	logic cmd_seen_q, overflow_seen_q, memory_seen_q, zero_seen_q;
	logic [LINE_W-1:0] line_count_q;
	logic zero_now, cmd_now, ovf_now, mem_now;

	// output register
	logic out_valid_q;
	logic [IDX_W-1:0] line_index_q;
	logic cmd_risk_q, overflow_risk_q, memory_risk_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign ctl.adv  = accept;
	assign ctl.clr  = line_end;

	// cell 0 starts every keyword with the empty prefix
	assign chain[0] = '1;

	for (genvar i = 0; i < CMP_LEN; i++) begin : g_cell
		if (i < CMP_LEN - 1) begin : g_mid
			kwrs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.pos    (POS_W'(i)),
				.ch     (ch),
				.prv    (chain[i]),
				.nxt    (chain[i+1]),
				.hit    (hits[i])
			);
		end else begin : g_last
			// the longest keyword ends here, nothing is handed on
			kwrs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.pos    (POS_W'(i)),
				.ch     (ch),
				.prv    (chain[i]),
				.nxt    (),
				.hit    (hits[i])
			);
		end
	end

	// a keyword ends at this byte if any cell reports it complete
	always_comb begin
		hit_all = '0;
		for (int i = 0; i < CMP_LEN; i++) begin
			hit_all = hit_all | hits[i];
		end
	end

	// a zero byte blocks matching for itself and the rest of its line
	assign zero_now = zero_seen_q || (ch == '0);
	assign cmd_now  = cmd_seen_q      || (!zero_now && |(hit_all & CMD_MASK));
	assign ovf_now  = overflow_seen_q || (!zero_now && |(hit_all & OVF_MASK));
	assign mem_now  = memory_seen_q   || (!zero_now && |(hit_all & MEM_MASK));

	// sticky flags and line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_seen_q      <= 1'b0;
			overflow_seen_q <= 1'b0;
			memory_seen_q   <= 1'b0;
			zero_seen_q     <= 1'b0;
			line_count_q    <= '0;
		end else if (accept) begin
			if (line_end) begin
				cmd_seen_q      <= 1'b0;
				overflow_seen_q <= 1'b0;
				memory_seen_q   <= 1'b0;
				zero_seen_q     <= 1'b0;
				if (line_count_q == LINE_W'(MAX_LINES - 1)) begin
					line_count_q <= '0;
				end else begin
					line_count_q <= line_count_q + 1'b1;
				end
			end else begin
				cmd_seen_q      <= cmd_now;
				overflow_seen_q <= ovf_now;
				memory_seen_q   <= mem_now;
				zero_seen_q     <= zero_now;
			end
		end
	end

	// output valid: set by a line end, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && line_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, loaded only when a line closes
	always_ff @(posedge clk) begin
		if (accept && line_end) begin
			line_index_q    <= IDX_W'(line_count_q);
			cmd_risk_q      <= cmd_now;
			overflow_risk_q <= ovf_now;
			memory_risk_q   <= mem_now;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_index    = line_index_q;
	assign cmd_risk      = cmd_risk_q;
	assign overflow_risk = overflow_risk_q;
	assign memory_risk   = memory_risk_q;

	`include "line_keyword_risk_scanner_assert.svh"

	// a closing byte always leaves a result behind
	`KWRS_ASSERT_NEXT(a_line_end_result, accept && line_end, out_valid_q)
	// a byte inside a line never creates a result
	`KWRS_ASSERT_NEXT(a_no_spurious_result, accept && !line_end && !out_valid_q, !out_valid_q)
	// flags start clean after every line
	`KWRS_ASSERT_NEXT(a_flags_cleared, accept && line_end,
		!cmd_seen_q && !overflow_seen_q && !memory_seen_q && !zero_seen_q)
	// the line counter moves exactly once per line
	`KWRS_ASSERT_NEXT(a_count_moves, accept && line_end, line_count_q != $past(line_count_q))
	// no item is taken while a held result is stalled
	`KWRS_ASSERT_NOW(a_hold_blocks, out_valid_q && out_stall, !accept)

endmodule
